>>> src/pip_pkg.sv
// shared types, codes and constants of the point in polygon classifier
package pip_pkg;

  localparam int CoordW = 31;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic [1:0]               func_t;
  typedef logic [1:0]               pos_t;

  localparam func_t FUNC_START  = 2'd0;
  localparam func_t FUNC_APPEND = 2'd1;
  localparam func_t FUNC_QUERY  = 2'd2;

  localparam pos_t POS_INSIDE  = 2'd0;
  localparam pos_t POS_BORDER  = 2'd1;
  localparam pos_t POS_OUTSIDE = 2'd2;

  typedef struct packed {
    logic   valid;
    logic   active;
    logic   last;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t px;
    coord_t py;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
    logic crossing;
  } edge_rsp_t;

endpackage

>>> src/pip_in_if.sv
// request channel: vertex loads and query points
interface pip_in_if;
  import pip_pkg::*;

  logic   valid;
  logic   ready;
  func_t  func;
  coord_t coord_x;
  coord_t coord_y;

  modport source (output valid, output func, output coord_x, output coord_y, input ready);
  modport sink (input valid, input func, input coord_x, input coord_y, output ready);
endinterface

>>> src/pip_out_if.sv
// response channel: classification of one query point
interface pip_out_if;
  import pip_pkg::*;

  logic valid;
  logic ready;
  pos_t position;
  logic truncated;

  modport source (output valid, output position, output truncated, input ready);
  modport sink (input valid, input position, input truncated, output ready);
endinterface

>>> src/pip_cell.sv
// one vertex cell of the rotating ring
module pip_cell (
  input  logic            clk,
  input  logic            load,
  input  pip_pkg::coord_t load_x,
  input  pip_pkg::coord_t load_y,
  input  logic            shift,
  input  pip_pkg::coord_t next_x,
  input  pip_pkg::coord_t next_y,
  output pip_pkg::coord_t x,
  output pip_pkg::coord_t y
);
  import pip_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      x <= load_x;
      y <= load_y;
    end else if (shift) begin
      x <= next_x;
      y <= next_y;
    end
  end
endmodule

>>> src/pip_edge.sv
// three stage edge tester: border hit and downward ray crossing for one edge
module pip_edge (
  input  logic                clk,
  input  logic                rst,
  input  pip_pkg::edge_req_t  req,
  output pip_pkg::edge_rsp_t  rsp
);
  import pip_pkg::*;

  coord_t ax, ay, bx, by;
  logic   swap;

  logic  a_valid, a_active, a_last, a_box, a_span;
  diff_t a_dx, a_dy, a_qx, a_qy;

  logic  b_valid, b_active, b_last, b_box, b_span;
  prod_t b_m1, b_m2;

  prod_t cr;

  // order endpoints so a is the left one, the lower one when x is equal
  always_comb begin
    swap = (req.bx < req.ax) || ((req.bx == req.ax) && (req.by < req.ay));
    ax = swap ? req.bx : req.ax;
    ay = swap ? req.by : req.ay;
    bx = swap ? req.ax : req.bx;
    by = swap ? req.ay : req.by;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= req.valid;
    end
    a_active <= req.active;
    a_last   <= req.last;
    a_dx     <= DiffW'(bx) - DiffW'(ax);
    a_dy     <= DiffW'(by) - DiffW'(ay);
    a_qx     <= DiffW'(req.px) - DiffW'(ax);
    a_qy     <= DiffW'(req.py) - DiffW'(ay);
    a_box    <= (req.px >= ax) && (req.px <= bx) &&
                (req.py >= ((ay < by) ? ay : by)) && (req.py <= ((ay < by) ? by : ay));
    a_span   <= (ax != bx) && (req.px >= ax) && (req.px < bx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_active <= a_active;
    b_last   <= a_last;
    b_box    <= a_box;
    b_span   <= a_span;
    b_m1     <= a_dx * a_qy;
    b_m2     <= a_dy * a_qx;
  end

  assign cr = b_m1 - b_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= b_valid;
    end
    rsp.last     <= b_last;
    rsp.hit      <= b_active && b_box && (cr == '0);
    rsp.crossing <= b_active && b_span && !cr[ProdW-1] && (cr != '0);
  end
endmodule

>>> src/point_in_polygon_classifier.sv
// top level: vertex ring, edge tester and query control
// Vertex loads (start, append) are taken while the control is idle. A query
// sweeps the stored edges, drains the edge tester and only then offers its result:
// the ring of vertex cells rotates once past the three stage edge tester, one
// edge per cycle, whatever the number of stored vertices. A finished result
// sits in an output register; loads are accepted while it waits, the next query
// once the previous result has left the control. Vertices appended to a full
// store are dropped and reported through truncated.
module point_in_polygon_classifier #(
  parameter int MAX_VERTICES = 64
) (
  input logic      clk,
  input logic      rst,
  pip_in_if.sink   req,
  pip_out_if.source rsp
);
  import pip_pkg::*;

  localparam int TW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic          overflow;
  logic [TW-1:0] step;
  logic          parity;
  logic          border;
  coord_t        px, py, first_x, first_y;

  coord_t        cell_x [MAX_VERTICES];
  coord_t        cell_y [MAX_VERTICES];
  logic          accept;
  logic          wr_en;
  logic [TW-1:0] wr_idx;
  logic          scan;
  logic          wrap;
  edge_req_t     ereq;
  edge_rsp_t     ersp;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign scan      = (state == ST_SCAN);

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = '0;
    if (accept && (req.func == FUNC_START)) begin
      wr_en = 1'b1;
    end else if (accept && (req.func == FUNC_APPEND) && (count < CW'(MAX_VERTICES))) begin
      wr_en  = 1'b1;
      wr_idx = count[TW-1:0];
    end
  end

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
    pip_cell u_cell (
      .clk    (clk),
      .load   (wr_en && (wr_idx == TW'(k))),
      .load_x (req.coord_x),
      .load_y (req.coord_y),
      .shift  (scan),
      .next_x (cell_x[(k + 1) % MAX_VERTICES]),
      .next_y (cell_y[(k + 1) % MAX_VERTICES]),
      .x      (cell_x[k]),
      .y      (cell_y[k])
    );
  end

  // the edge leaving the last stored vertex closes on the first one
  assign wrap = (CW'(step) == (count - CW'(1)));

  always_comb begin
    ereq.valid  = scan;
    ereq.active = CW'(step) < count;
    ereq.last   = (step == TW'(MAX_VERTICES - 1));
    ereq.ax     = cell_x[0];
    ereq.ay     = cell_y[0];
    ereq.bx     = wrap ? first_x : cell_x[1];
    ereq.by     = wrap ? first_y : cell_y[1];
    ereq.px     = px;
    ereq.py     = py;
  end

  pip_edge u_edge (
    .clk (clk),
    .rst (rst),
    .req (ereq),
    .rsp (ersp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.func)
              FUNC_START: begin
                count    <= CW'(1);
                overflow <= 1'b0;
              end
              FUNC_APPEND: begin
                if (count < CW'(MAX_VERTICES)) begin
                  count <= count + CW'(1);
                end else begin
                  overflow <= 1'b1;
                end
              end
              FUNC_QUERY: begin
                state <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (step == TW'(MAX_VERTICES - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (ersp.valid && ersp.last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (accept && (req.func == FUNC_QUERY)) begin
      px      <= req.coord_x;
      py      <= req.coord_y;
      first_x <= cell_x[0];
      first_y <= cell_y[0];
      step    <= '0;
      parity  <= 1'b0;
      border  <= 1'b0;
    end else begin
      if (scan) begin
        step <= step + TW'(1);
      end
      if (ersp.valid) begin
        parity <= parity ^ ersp.crossing;
        border <= border | ersp.hit;
      end
    end
    if ((state == ST_DONE) && (!rsp.valid || rsp.ready)) begin
      rsp.position  <= border ? POS_BORDER : (parity ? POS_INSIDE : POS_OUTSIDE);
      rsp.truncated <= overflow;
    end
  end
endmodule
